// ===== hdl/pse_pkg.sv =====
package pse_pkg;

    localparam int DEFAULT_STACK_DEPTH = 16;
    localparam int DATA_W = 32;
    localparam int TYPE_W = 3;
    localparam int STATUS_W = 2;

    localparam logic [TYPE_W-1:0] OP_PUSH = 3'd0;
    localparam logic [TYPE_W-1:0] OP_ADD  = 3'd1;
    localparam logic [TYPE_W-1:0] OP_SUB  = 3'd2;
    localparam logic [TYPE_W-1:0] OP_MUL  = 3'd3;
    localparam logic [TYPE_W-1:0] OP_DIV  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZERO   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

    // Request token as queued by the front end
    typedef struct packed {
        logic [TYPE_W-1:0]        kind;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } pse_tok_t;

    // Saturate a 64-bit signed value to 32 bits
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/pse_front.sv =====
module pse_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [2:0]              s_req_type,
    input  logic signed [31:0]      s_operand_value,
    input  logic                    s_last_token,
    input  logic                    s_valid,
    output logic                    s_ready,
    output pse_pkg::pse_tok_t       q_data,
    output logic                    q_valid,
    input  logic                    q_ready
);
    import pse_pkg::*;

    // Two-entry queue toward the back end
    pse_tok_t   buf_reg [2];
    logic       wp_reg, rp_reg, wp_next, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = buf_reg[rp_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    // Store request
    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wp_reg] <= '{kind: s_req_type, value: s_operand_value,
                                 last: s_last_token};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

// ===== hdl/pse_div.sv =====
module pse_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quo
);
    import pse_pkg::*;

    // Restoring divide of |num|<<16 by |den|, one bit a cycle
    logic [47:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg;
    logic        neg_reg;
    logic [5:0]  n_reg, n_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;
    logic [48:0] mag;

    assign trial = {r_reg[31:0], q_reg[47]} - {1'b0, d_reg};

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        n_next    = n_reg;
        busy_next = busy_reg;
        done      = 1'b0;
        if (busy_reg) begin
            if (trial[32]) begin
                r_next = {r_reg[31:0], q_reg[47]};
                q_next = {q_reg[46:0], 1'b0};
            end else begin
                r_next = trial;
                q_next = {q_reg[46:0], 1'b1};
            end
            n_next = n_reg - 6'd1;
            if (n_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end else if (n_reg == 6'd0 && !start) begin
            busy_next = 1'b0;
        end
        done = !busy_reg && (n_reg == 6'd0) && r_reg[32];
    end

    // Sign-apply and saturate quotient
    always_comb begin
        mag = {1'b0, q_reg};
        quo = sat32(neg_reg ? -$signed({15'd0, mag}) : $signed({15'd0, mag}));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            n_reg    <= 6'd0;
            r_reg    <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            n_reg    <= 6'd48;
            r_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            n_reg    <= n_next;
            r_reg    <= (busy_reg && n_reg == 6'd1) ? {1'b1, r_next[31:0]}
                        : (busy_reg ? {1'b0, r_next[31:0]} : {1'b0, r_reg[31:0]});
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= {(num[31] ? 32'(-num) : 32'(num)), 16'd0};
            d_reg   <= den[31] ? 32'(-den) : 32'(den);
            neg_reg <= num[31] ^ den[31];
        end else if (busy_reg) begin
            q_reg <= q_next;
        end
    end
endmodule

// ===== hdl/pse_back.sv =====
module pse_back #(
    parameter int STACK_DEPTH = pse_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  pse_pkg::pse_tok_t  q_data,
    input  logic               q_valid,
    output logic               q_ready,
    output logic signed [31:0] m_result_value,
    output logic [1:0]         m_status_code,
    output logic               m_valid,
    input  logic               m_ready
);
    import pse_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PW = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_WB   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic signed [31:0] mem [STACK_DEPTH];
    logic [2:0]         st_reg, st_next;
    logic [PW-1:0]      sp_reg, sp_next;
    logic [1:0]         err_reg, err_next;
    pse_tok_t           tok_reg;
    logic signed [31:0] t_reg, s_reg, res_reg, rd_reg;
    logic signed [63:0] prod_reg;
    logic               wr_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic signed [31:0] wr_data;
    logic               div_start, div_done;
    logic signed [31:0] div_quo;
    logic [1:0]         rd_cnt_reg;
    logic signed [31:0] out_val_reg;
    logic [1:0]         out_st_reg;

    pse_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(s_reg), .den(t_reg), .done(div_done), .quo(div_quo)
    );

    assign q_ready        = (st_reg == S_IDLE);
    assign m_valid        = (st_reg == S_OUT);
    assign m_result_value = out_val_reg;
    assign m_status_code  = out_st_reg;

    // Stack memory with registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    always_comb begin
        st_next   = st_reg;
        sp_next   = sp_reg;
        err_next  = err_reg;
        wr_en     = 1'b0;
        wr_addr   = AW'(sp_reg);
        wr_data   = res_reg;
        rd_addr   = AW'(sp_reg - PW'(1));
        div_start = 1'b0;
        case (st_reg)
            S_IDLE: begin
                if (q_valid) begin
                    st_next = S_RD;
                end
            end
            S_RD: begin
                // classify and dispatch the token
                if (err_reg != ST_OK || tok_reg.kind > OP_DIV) begin
                    st_next = S_FIN;
                end else if (tok_reg.kind == OP_PUSH) begin
                    if (sp_reg >= PW'(STACK_DEPTH)) begin
                        err_next = ST_OVERFLOW;
                    end else begin
                        wr_en   = 1'b1;
                        wr_data = tok_reg.value;
                        sp_next = sp_reg + PW'(1);
                    end
                    st_next = S_FIN;
                end else if (sp_reg < PW'(2)) begin
                    err_next = ST_UNDERFLOW;
                    st_next  = S_FIN;
                end else begin
                    rd_addr = AW'(sp_reg - PW'(1));
                    st_next = S_EXEC;
                end
            end
            S_EXEC: begin
                rd_addr = AW'(sp_reg - PW'(2));
                if (rd_cnt_reg == 2'd2) begin
                    sp_next = sp_reg - PW'(2);
                    case (tok_reg.kind)
                        OP_ADD, OP_SUB: st_next = S_WB;
                        OP_MUL:         st_next = S_MUL;
                        default: begin
                            if (t_reg == 32'sd0) begin
                                err_next = ST_DIVZERO;
                                st_next  = S_FIN;
                            end else begin
                                div_start = 1'b1;
                                st_next   = S_DIV;
                            end
                        end
                    endcase
                end
            end
            S_MUL: st_next = S_WB;
            S_DIV: begin
                if (div_done) begin
                    st_next = S_WB;
                end
            end
            S_WB: begin
                wr_en   = 1'b1;
                sp_next = sp_reg + PW'(1);
                st_next = S_FIN;
            end
            S_FIN: begin
                rd_addr = AW'(sp_reg - PW'(1));
                if (tok_reg.last) begin
                    if (err_reg == ST_OK && sp_reg == '0) begin
                        err_next = ST_UNDERFLOW;
                    end
                    st_next = (rd_cnt_reg == 2'd1) ? S_OUT : S_FIN;
                end else begin
                    st_next = S_IDLE;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    sp_next  = '0;
                    err_next = ST_OK;
                    st_next  = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (st_reg == S_IDLE && q_valid) begin
            tok_reg <= q_data;
        end
        // count cycles spent in S_EXEC or S_FIN, restart on every state change
        if (st_next != st_reg) begin
            rd_cnt_reg <= 2'd0;
        end else if (st_reg == S_EXEC || st_reg == S_FIN) begin
            rd_cnt_reg <= rd_cnt_reg + 2'd1;
        end else begin
            rd_cnt_reg <= 2'd0;
        end
        if (st_reg == S_EXEC && rd_cnt_reg == 2'd0) begin
            t_reg <= rd_reg;
        end
        if (st_reg == S_EXEC && rd_cnt_reg == 2'd1) begin
            s_reg <= rd_reg;
        end
        if (st_reg == S_EXEC && rd_cnt_reg == 2'd2) begin
            case (tok_reg.kind)
                OP_ADD:  res_reg <= sat32(64'(s_reg) + 64'(t_reg));
                OP_SUB:  res_reg <= sat32(64'(s_reg) - 64'(t_reg));
                default: res_reg <= res_reg;
            endcase
            prod_reg <= 64'(s_reg) * 64'(t_reg);
        end
        if (st_reg == S_MUL) begin
            res_reg <= sat32(prod_reg / 64'sd65536);
        end
        if (st_reg == S_DIV && div_done) begin
            res_reg <= div_quo;
        end
        if (st_reg == S_FIN && rd_cnt_reg == 2'd1) begin
            out_st_reg  <= err_next;
            out_val_reg <= (err_next == ST_OK) ? rd_reg : 32'sd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= S_IDLE;
            sp_reg  <= '0;
            err_reg <= ST_OK;
        end else begin
            st_reg  <= st_next;
            sp_reg  <= sp_next;
            err_reg <= err_next;
        end
    end
endmodule

// ===== hdl/postfix_stack_evaluator.sv =====
// Sequence: a push is written to the stack in S_RD; an operator reads both
// operands in S_EXEC, passes S_MUL or the 48-step serial divider (S_DIV) and
// writes back in S_WB; a last token reads the stack top in S_FIN for output.
// Throughput: one token at a time in the back end; a two-entry queue lets
// the input keep accepting while the back end works, until both entries fill.
// Reset: synchronous, active-low aresetn empties the stack and clears errors.
module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = pse_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [2:0]         s_req_type,
    input  logic signed [31:0] s_operand_value,
    input  logic               s_last_token,
    input  logic               s_valid,
    output logic               s_ready,
    output logic signed [31:0] m_result_value,
    output logic [1:0]         m_status_code,
    output logic               m_valid,
    input  logic               m_ready
);
    import pse_pkg::*;

    pse_tok_t q_data;
    logic     q_valid, q_ready;

    pse_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_req_type(s_req_type), .s_operand_value(s_operand_value),
        .s_last_token(s_last_token), .s_valid(s_valid), .s_ready(s_ready),
        .q_data(q_data), .q_valid(q_valid), .q_ready(q_ready)
    );

    pse_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_data(q_data), .q_valid(q_valid), .q_ready(q_ready),
        .m_result_value(m_result_value), .m_status_code(m_status_code),
        .m_valid(m_valid), .m_ready(m_ready)
    );
endmodule
